/* rtl/core/pphit_pkg.sv */
`timescale 1ns / 1ps
package pphit_pkg;

   localparam int COORD_BITS_DEFAULT   = 12;
   localparam int MAX_BRANCHES_DEFAULT = 256;
   localparam int QUEUE_DEPTH          = 4;

   localparam int FIELD_COORD_BITS = 12;
   localparam int STRIDE_BITS      = 16;
   localparam int TOL_BITS         = 4;
   localparam int TOL_SQ_BITS      = 8;
   localparam int INDEX_BITS       = 24;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 16;
   localparam int MAG_LIMIT_BITS   = 21;

   localparam logic [INDEX_BITS-1:0]  INDEX_MAX    = 24'hFFFFFF;
   localparam logic [TOL_BITS-1:0]    TOL_RESET    = 4'd5;
   localparam logic [TOL_SQ_BITS-1:0] TOL_SQ_RESET = 8'd25;
   localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 16'd1;

   typedef enum logic [1:0] {
      KIND_POINT      = 2'd0,
      KIND_STROKE_END = 2'd1,
      KIND_BRANCH_END = 2'd2,
      KIND_GRAPH_END  = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_QUERY_X     = 3'd0,
      CSR_QUERY_Y     = 3'd1,
      CSR_SYMBOL_MODE = 3'd2,
      CSR_STRIDE      = 3'd3,
      CSR_TOLERANCE   = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_TEST      = 1'b0,
      OP_GRAPH_END = 1'b1
   } op_type;

   typedef struct packed {
      logic [FIELD_COORD_BITS-1:0] query_x;
      logic [FIELD_COORD_BITS-1:0] query_y;
      logic                        symbol_mode;
      logic [STRIDE_BITS-1:0]      stride;
      logic [TOL_BITS-1:0]         tol;
      logic [TOL_SQ_BITS-1:0]      tol_sq;
   } cfg_type;

endpackage

/* rtl/core/pphit_queue.sv */
`timescale 1ns / 1ps
module pphit_queue
   import pphit_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTRW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

/* rtl/core/pphit_front.sv */
`timescale 1ns / 1ps
module pphit_front
   import pphit_pkg::*;
#(
   parameter int COORD_BITS   = COORD_BITS_DEFAULT,
   parameter int MAX_BRANCHES = MAX_BRANCHES_DEFAULT,
   localparam int BRW         = $clog2(MAX_BRANCHES)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        symbol_mode,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  kind_type                    in_kind,
   input  logic [FIELD_COORD_BITS-1:0] in_x,
   input  logic [FIELD_COORD_BITS-1:0] in_y,
   input  logic                        q_full,
   output logic                        push,
   output op_type                      push_op,
   output logic [BRW-1:0]              push_branch,
   output logic [COORD_BITS-1:0]       push_x1,
   output logic [COORD_BITS-1:0]       push_y1,
   output logic [COORD_BITS-1:0]       push_x2,
   output logic [COORD_BITS-1:0]       push_y2
);

   localparam int CW = COORD_BITS;

   logic [CW-1:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic           prev_valid_ff, prev_valid_in;
   logic [BRW-1:0] branch_ff, branch_in, branch_inc;
   logic [CW-1:0]  px, py;
   logic           accept;

   assign px       = CW'(in_x);
   assign py       = CW'(in_y);
   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   assign branch_inc  = (branch_ff == BRW'(MAX_BRANCHES - 1)) ? branch_ff : branch_ff + 1'b1;
   assign push_op     = (in_kind == KIND_GRAPH_END) ? OP_GRAPH_END : OP_TEST;
   assign push_branch = branch_ff;
   assign push_x1     = symbol_mode ? px : prev_x_ff;
   assign push_y1     = symbol_mode ? py : prev_y_ff;
   assign push_x2     = px;
   assign push_y2     = py;

   always_comb begin
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      prev_valid_in = prev_valid_ff;
      branch_in     = branch_ff;
      push          = 1'b0;
      if (accept) begin
         case (in_kind)
            KIND_POINT: begin
               push          = symbol_mode || prev_valid_ff;
               prev_x_in     = px;
               prev_y_in     = py;
               prev_valid_in = 1'b1;
            end
            KIND_STROKE_END: begin
               if (symbol_mode) begin
                  branch_in = branch_inc;
               end
            end
            KIND_BRANCH_END: begin
               branch_in     = branch_inc;
               prev_valid_in = 1'b0;
            end
            KIND_GRAPH_END: begin
               push          = 1'b1;
               branch_in     = '0;
               prev_valid_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_valid_ff <= 1'b0;
         branch_ff     <= '0;
      end else begin
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         prev_valid_ff <= prev_valid_in;
         branch_ff     <= branch_in;
      end
   end

endmodule

/* rtl/core/pphit_back.sv */
`timescale 1ns / 1ps
module pphit_back
   import pphit_pkg::*;
#(
   parameter int COORD_BITS   = COORD_BITS_DEFAULT,
   parameter int MAX_BRANCHES = MAX_BRANCHES_DEFAULT,
   localparam int BRW         = $clog2(MAX_BRANCHES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  op_type                q_op,
   input  logic [BRW-1:0]        q_branch,
   input  logic [COORD_BITS-1:0] q_x1,
   input  logic [COORD_BITS-1:0] q_y1,
   input  logic [COORD_BITS-1:0] q_x2,
   input  logic [COORD_BITS-1:0] q_y2,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  out_hit,
   output logic [INDEX_BITS-1:0] out_index
);

   localparam int CW   = COORD_BITS;
   localparam int DW   = CW + 1;
   localparam int PW2  = 2 * DW;
   localparam int LW   = 2 * CW + 1;
   localparam int BDW  = LW + TOL_SQ_BITS;
   localparam int M2W  = 2 * MAG_LIMIT_BITS;
   localparam int CMPW = (BDW > M2W) ? BDW : M2W;
   localparam int PIW  = (BRW + STRIDE_BITS > INDEX_BITS) ? BRW + STRIDE_BITS : INDEX_BITS;

   logic adv;

   // stage 1: box test and differences
   logic [DW-1:0]        qxe, qye, tolw, x1e, y1e, x2e, y2e;
   logic                 lo_x, hi_x, lo_y, hi_y;
   logic                 box_in;
   logic signed [DW-1:0] sx_in, sy_in, dx_in, dy_in;
   logic                 v1_ff, box1_ff;
   op_type               op1_ff;
   logic [BRW-1:0]       br1_ff;
   logic signed [DW-1:0] sx_ff, sy_ff, dx_ff, dy_ff;

   // stage 2: products
   logic signed [PW2-1:0] pa_in, pb_in, sqx_in, sqy_in;
   logic [PIW-1:0]        idx_in;
   logic                  v2_ff, box2_ff;
   op_type                op2_ff;
   logic signed [PW2-1:0] pa_ff, pb_ff, sqx_ff, sqy_ff;
   logic [PIW-1:0]        idx_ff;

   // stage 3: cross magnitude squared, bound
   logic signed [PW2:0]       cross_val;
   logic [PW2:0]              mag;
   logic [MAG_LIMIT_BITS-1:0] mag_lo;
   logic                      small_in;
   logic [M2W-1:0]            mag2_in;
   logic [LW-1:0]             len2;
   logic [BDW-1:0]            bound_in;
   logic [INDEX_BITS-1:0]     idx_sat_in;
   logic                      v3_ff, box3_ff, small3_ff;
   op_type                    op3_ff;
   logic [M2W-1:0]            mag2_ff;
   logic [BDW-1:0]            bound_ff;
   logic [INDEX_BITS-1:0]     idx3_ff;

   // result
   logic                  hit3;
   logic                  found_ff, found_in;
   logic [INDEX_BITS-1:0] found_idx_ff, found_idx_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_hit_ff, out_hit_in;
   logic [INDEX_BITS-1:0] out_index_ff, out_index_in;

   assign adv   = !out_valid_ff || out_ready;
   assign q_pop = adv && !q_empty;

   assign qxe  = DW'(CW'(cfg.query_x));
   assign qye  = DW'(CW'(cfg.query_y));
   assign tolw = DW'(cfg.tol);
   assign x1e  = DW'(q_x1);
   assign y1e  = DW'(q_y1);
   assign x2e  = DW'(q_x2);
   assign y2e  = DW'(q_y2);

   assign lo_x   = (qxe + tolw < x1e) && (qxe + tolw < x2e);
   assign hi_x   = (qxe > x1e + tolw) && (qxe > x2e + tolw);
   assign lo_y   = (qye + tolw < y1e) && (qye + tolw < y2e);
   assign hi_y   = (qye > y1e + tolw) && (qye > y2e + tolw);
   assign box_in = !(lo_x || hi_x || lo_y || hi_y);

   assign sx_in = signed'(x2e - x1e);
   assign sy_in = signed'(y2e - y1e);
   assign dx_in = signed'(qxe - x1e);
   assign dy_in = signed'(qye - y1e);

   assign pa_in  = sx_ff * dy_ff;
   assign pb_in  = dx_ff * sy_ff;
   assign sqx_in = sx_ff * sx_ff;
   assign sqy_in = sy_ff * sy_ff;
   assign idx_in = PIW'(br1_ff) * PIW'(cfg.stride);

   assign cross_val  = (PW2 + 1)'(pa_ff) - (PW2 + 1)'(pb_ff);
   assign mag        = cross_val[PW2] ? unsigned'(-cross_val) : unsigned'(cross_val);
   assign small_in   = ((mag >> MAG_LIMIT_BITS) == '0);
   assign mag_lo     = MAG_LIMIT_BITS'(mag);
   assign mag2_in    = M2W'(mag_lo) * M2W'(mag_lo);
   assign len2       = LW'(unsigned'(sqx_ff)) + LW'(unsigned'(sqy_ff));
   assign bound_in   = BDW'(len2) * BDW'(cfg.tol_sq);
   assign idx_sat_in = (idx_ff > PIW'(INDEX_MAX)) ? INDEX_MAX : idx_ff[INDEX_BITS-1:0];

   assign hit3 = box3_ff && small3_ff && (CMPW'(mag2_ff) <= CMPW'(bound_ff));

   always_comb begin
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      out_valid_in = out_valid_ff;
      out_hit_in   = out_hit_ff;
      out_index_in = out_index_ff;
      if (adv) begin
         if (out_ready) begin
            out_valid_in = 1'b0;
         end
         if (v3_ff) begin
            case (op3_ff)
               OP_TEST: begin
                  if (hit3 && !found_ff) begin
                     found_in     = 1'b1;
                     found_idx_in = idx3_ff;
                  end
               end
               OP_GRAPH_END: begin
                  out_valid_in = 1'b1;
                  out_hit_in   = found_ff;
                  out_index_in = found_ff ? found_idx_ff : '0;
                  found_in     = 1'b0;
                  found_idx_in = '0;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         found_ff     <= 1'b0;
         found_idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            v1_ff <= !q_empty;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
         found_ff     <= found_in;
         found_idx_ff <= found_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff    <= q_op;
         br1_ff    <= q_branch;
         box1_ff   <= box_in;
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         op2_ff    <= op1_ff;
         box2_ff   <= box1_ff;
         pa_ff     <= pa_in;
         pb_ff     <= pb_in;
         sqx_ff    <= sqx_in;
         sqy_ff    <= sqy_in;
         idx_ff    <= idx_in;
         op3_ff    <= op2_ff;
         box3_ff   <= box2_ff;
         small3_ff <= small_in;
         mag2_ff   <= mag2_in;
         bound_ff  <= bound_in;
         idx3_ff   <= idx_sat_in;
      end
      out_hit_ff   <= out_hit_in;
      out_index_ff <= out_index_in;
   end

   assign out_valid = out_valid_ff;
   assign out_hit   = out_hit_ff;
   assign out_index = out_index_ff;

endmodule

/* rtl/core/polyline_pick_hit_test_core.sv */
`timescale 1ns / 1ps
// Polyline pick test: decides whether the configured query point picks one graph.
// req channel: one word per point or marker. tuser carries the item kind (point,
//   stroke end, branch end, graph end); tdata carries point x and y.
// rsp channel: one word per graph end. tuser is the hit flag, tdata the hit index
//   (branch number times stride of the first hit, zero on a miss).
// csr channel: index and data of one register, always ready; write only while
//   no graph is in flight.
// Throughput: one req word per cycle while the queue has room. The front end pairs
//   points into segments (symbol mode: one point per segment) and pushes them into
//   a four-entry queue; the back end evaluates one segment per cycle unless rsp
//   stalls, in a three-stage pipeline (differences, products, squared compare).
// Stall: while rsp waits, the back end holds; the front end keeps taking words
//   until the queue fills, then drops req_tready.
// Reset: synchronous; clears the queue, the pipeline, the per-graph state and
//   loads the register defaults (stride one, tolerance five pixels).
module polyline_pick_hit_test_core
   import pphit_pkg::*;
#(
   parameter int COORD_BITS   = COORD_BITS_DEFAULT,
   parameter int MAX_BRANCHES = MAX_BRANCHES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [23:0]               req_tdata,  // point_x, point_y
   input  logic [1:0]                req_tuser,  // item_kind
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [INDEX_BITS-1:0]     rsp_tdata,  // hit_index
   output logic                      rsp_tuser,  // hit
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int CW  = COORD_BITS;
   localparam int BRW = $clog2(MAX_BRANCHES);
   localparam int QW  = 1 + BRW + 4 * CW;

   cfg_type        cfg_ff;
   logic           q_full, q_empty, q_pop, push;
   op_type         push_op;
   logic [BRW-1:0] push_branch;
   logic [CW-1:0]  push_x1, push_y1, push_x2, push_y2;
   logic [QW-1:0]  q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.query_x     <= '0;
         cfg_ff.query_y     <= '0;
         cfg_ff.symbol_mode <= 1'b0;
         cfg_ff.stride      <= STRIDE_RESET;
         cfg_ff.tol         <= TOL_RESET;
         cfg_ff.tol_sq      <= TOL_SQ_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_QUERY_X:     cfg_ff.query_x     <= csr_data[FIELD_COORD_BITS-1:0];
            CSR_QUERY_Y:     cfg_ff.query_y     <= csr_data[FIELD_COORD_BITS-1:0];
            CSR_SYMBOL_MODE: cfg_ff.symbol_mode <= csr_data[0];
            CSR_STRIDE:      cfg_ff.stride      <= csr_data;
            CSR_TOLERANCE: begin
               cfg_ff.tol    <= csr_data[TOL_BITS-1:0];
               cfg_ff.tol_sq <= TOL_SQ_BITS'(csr_data[TOL_BITS-1:0])
                                * TOL_SQ_BITS'(csr_data[TOL_BITS-1:0]);
            end
            default: ;
         endcase
      end
   end

   pphit_front #(
      .COORD_BITS   (COORD_BITS),
      .MAX_BRANCHES (MAX_BRANCHES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .symbol_mode (cfg_ff.symbol_mode),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_kind     (kind_type'(req_tuser)),
      .in_x        (req_tdata[11:0]),
      .in_y        (req_tdata[23:12]),
      .q_full      (q_full),
      .push        (push),
      .push_op     (push_op),
      .push_branch (push_branch),
      .push_x1     (push_x1),
      .push_y1     (push_y1),
      .push_x2     (push_x2),
      .push_y2     (push_y2)
   );

   assign q_wdata = {push_op, push_branch, push_y2, push_x2, push_y1, push_x1};

   pphit_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   pphit_back #(
      .COORD_BITS   (COORD_BITS),
      .MAX_BRANCHES (MAX_BRANCHES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_op      (op_type'(q_rdata[QW-1])),
      .q_branch  (q_rdata[4*CW+BRW-1:4*CW]),
      .q_x1      (q_rdata[CW-1:0]),
      .q_y1      (q_rdata[2*CW-1:CW]),
      .q_x2      (q_rdata[3*CW-1:2*CW]),
      .q_y2      (q_rdata[4*CW-1:3*CW]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (rsp_tuser),
      .out_index (rsp_tdata)
   );

endmodule

/* rtl/core/pphit_checker.sv */
`timescale 1ns / 1ps
module pphit_checker
   import pphit_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [1:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [INDEX_BITS-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   logic [4:0] pend_ff, pend_in;
   logic       end_in, end_out;

   assign end_in  = req_tvalid && req_tready && (req_tuser == KIND_GRAPH_END);
   assign end_out = rsp_tvalid && rsp_tready;

   always_comb begin
      pend_in = pend_ff;
      if (end_in && !end_out) begin
         pend_in = pend_ff + 1'b1;
      end else if (end_out && !end_in) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss carries a non-zero index");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_rsp_has_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != '0)
      else $error("rsp word without a pending graph end");

endmodule

bind polyline_pick_hit_test_core pphit_checker u_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
   import pphit_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 12;
   localparam logic [7:0] BRANCH_CAP = 8'(MAX_BRANCHES_DEFAULT - 1);

   typedef struct {
      kind_type    kind;
      logic [11:0] x;
      logic [11:0] y;
      bit          drain;
   } pick_item_type;

   typedef struct {
      logic                  hit;
      logic [INDEX_BITS-1:0] hit_index;
   } pick_result_type;

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [23:0]               req_tdata  = '0;
   logic [1:0]                req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [INDEX_BITS-1:0]     rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   // register copies and per-graph pick state
   logic [11:0] cfg_qx = '0, cfg_qy = '0;
   logic        cfg_symbol = 1'b0;
   logic [15:0] cfg_stride = STRIDE_RESET;
   logic [3:0]  cfg_tol = TOL_RESET;
   logic [11:0] last_x = '0, last_y = '0;
   logic        last_valid = 1'b0;
   logic [7:0]  branch_no = '0;
   logic        picked = 1'b0;
   logic [23:0] picked_index = '0;

   pick_item_type   items_to_send[$];
   pick_result_type results_due[$];
   pick_item_type   on_bus;
   pick_result_type want;
   int              req_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              mismatches = 0;
   int              queued_in_phase = 0;
   int              quiet_cycles = 0;
   bit              drain_next = 1'b0;

   polyline_pick_hit_test_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit outside_band(longint q, longint a, longint b, longint t);
      return (q < a - t && q < b - t) || (q > a + t && q > b + t);
   endfunction

   function automatic bit segment_picked(longint ax, longint ay, longint bx, longint by);
      longint qx, qy, t, sx, sy, cross_val, mag;
      qx = cfg_qx;
      qy = cfg_qy;
      t  = cfg_tol;
      if (outside_band(qx, ax, bx, t) || outside_band(qy, ay, by, t))
         return 1'b0;
      sx = bx - ax;
      sy = by - ay;
      cross_val = sx * (qy - ay) - (qx - ax) * sy;
      mag = (cross_val < 0) ? -cross_val : cross_val;
      if (mag >= (longint'(1) << MAG_LIMIT_BITS))
         return 1'b0;
      return mag * mag <= t * t * (sx * sx + sy * sy);
   endfunction

   function automatic void note_pick();
      longint prod;
      if (picked)
         return;
      prod = longint'(branch_no) * longint'(cfg_stride);
      if (prod > longint'(INDEX_MAX))
         prod = longint'(INDEX_MAX);
      picked = 1'b1;
      picked_index = prod[23:0];
   endfunction

   function automatic void bump_branch();
      if (branch_no < BRANCH_CAP)
         branch_no = branch_no + 8'd1;
   endfunction

   function automatic void track_pick_item(pick_item_type it);
      longint dx, dy, t;
      pick_result_type res;
      t = cfg_tol;
      case (it.kind)
         KIND_POINT: begin
            if (cfg_symbol) begin
               dx = longint'(cfg_qx) - longint'(it.x);
               dy = longint'(cfg_qy) - longint'(it.y);
               if (dx >= -t && dx <= t && dy >= -t && dy <= t)
                  note_pick();
            end else if (last_valid && segment_picked(last_x, last_y, it.x, it.y)) begin
               note_pick();
            end
            last_x = it.x;
            last_y = it.y;
            last_valid = 1'b1;
         end
         KIND_STROKE_END: begin
            if (cfg_symbol)
               bump_branch();
         end
         KIND_BRANCH_END: begin
            bump_branch();
            last_valid = 1'b0;
         end
         default: begin
            res.hit = picked;
            res.hit_index = picked ? picked_index : '0;
            results_due.push_back(res);
            last_valid = 1'b0;
            branch_no = '0;
            picked = 1'b0;
            picked_index = '0;
         end
      endcase
   endfunction

   // driver: hold a word until taken, then advance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            track_pick_item(on_bus);
         if (!req_tvalid || req_tready) begin
            if (items_to_send.size() != 0 && $urandom_range(0, 99) >= req_idle_pct &&
                !(items_to_send[0].drain && results_due.size() != 0)) begin
               on_bus = items_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= on_bus.kind;
               req_tdata <= {on_bus.y, on_bus.x};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result word with the oldest one due
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               $display("%0t: result with none due, expected none, actual hit %0b index %0d",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               if (rsp_tuser !== want.hit) begin
                  $display("%0t: hit mismatch, expected %0b, actual %0b",
                           $time, want.hit, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata !== want.hit_index) begin
                  $display("%0t: hit_index mismatch, expected %0d, actual %0d",
                           $time, want.hit_index, rsp_tdata);
                  mismatches++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_QUERY_X:     cfg_qx = value[11:0];
         CSR_QUERY_Y:     cfg_qy = value[11:0];
         CSR_SYMBOL_MODE: cfg_symbol = value[0];
         CSR_STRIDE:      cfg_stride = value;
         default:         cfg_tol = value[3:0];
      endcase
   endtask

   task automatic set_config(logic [11:0] qx, logic [11:0] qy, logic mode,
                             logic [15:0] stride, logic [3:0] tol);
      write_reg(CSR_QUERY_X, 16'(qx));
      write_reg(CSR_QUERY_Y, 16'(qy));
      write_reg(CSR_SYMBOL_MODE, 16'(mode));
      write_reg(CSR_STRIDE, stride);
      write_reg(CSR_TOLERANCE, 16'(tol));
      csr_valid <= 1'b0;
   endtask

   // wait for every word sent and every result back, then let the pipeline drain
   task automatic settle();
      while (items_to_send.size() != 0 || req_tvalid || results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_item(kind_type kind, logic [11:0] x, logic [11:0] y);
      pick_item_type it;
      it.kind = kind;
      it.x = x;
      it.y = y;
      it.drain = drain_next;
      drain_next = 1'b0;
      items_to_send.push_back(it);
      queued_in_phase++;
   endtask

   task automatic queue_marker(kind_type kind);
      queue_item(kind, 12'($urandom), 12'($urandom));
   endtask

   function automatic logic [11:0] near_coord(logic [11:0] q, int spread);
      int v;
      v = int'(q) - spread + int'($urandom_range(0, 2 * spread));
      if (v < 0)
         v = 0;
      else if (v > 4095)
         v = 4095;
      return 12'(v);
   endfunction

   task automatic queue_point(int spread);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65)
         queue_item(KIND_POINT, near_coord(cfg_qx, spread), near_coord(cfg_qy, spread));
      else if (r < 75)
         queue_item(KIND_POINT, cfg_qx, cfg_qy);
      else if (r < 85)
         queue_item(KIND_POINT, {12{r[0]}}, {12{r[1]}});
      else
         queue_item(KIND_POINT, 12'($urandom), 12'($urandom));
   endtask

   task automatic queue_graph(int spread, bit must_drain);
      int unsigned branches, strokes;
      drain_next = must_drain || ($urandom_range(0, 7) == 0);
      branches = $urandom_range(1, 2);
      for (int b = 0; b < branches; b++) begin
         strokes = $urandom_range(1, 2);
         for (int s = 0; s < strokes; s++) begin
            repeat ($urandom_range(1, 3)) queue_point(spread);
            if ($urandom_range(0, 19) == 0)
               queue_item(kind_type'($urandom_range(0, 3)), 12'($urandom), 12'($urandom));
            if (s + 1 < strokes)
               queue_marker(KIND_STROKE_END);
         end
         if (b + 1 < branches || $urandom_range(0, 1) == 1)
            queue_marker(KIND_BRANCH_END);
      end
      queue_marker(KIND_GRAPH_END);
   endtask

   initial begin
      int graphs;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // segment mode around a query at (100, 100)
      set_config(12'd100, 12'd100, 1'b0, 16'd3, 4'd5);
      queue_item(KIND_POINT, 12'd94, 12'd50);
      queue_item(KIND_POINT, 12'd94, 12'd150);
      queue_marker(KIND_GRAPH_END);
      queue_marker(KIND_BRANCH_END);
      queue_item(KIND_POINT, 12'd0, 12'd4095);
      queue_item(KIND_POINT, 12'd4095, 12'd0);
      queue_marker(KIND_STROKE_END);
      queue_item(KIND_POINT, 12'd105, 12'd50);
      queue_item(KIND_POINT, 12'd105, 12'd150);
      queue_item(KIND_POINT, 12'd100, 12'd100);
      queue_marker(KIND_GRAPH_END);
      queue_item(KIND_POINT, 12'd100, 12'd100);
      queue_item(KIND_POINT, 12'd100, 12'd100);
      queue_marker(KIND_BRANCH_END);
      queue_marker(KIND_GRAPH_END);
      queue_item(KIND_POINT, 12'd103, 12'd103);
      queue_marker(KIND_BRANCH_END);
      queue_item(KIND_POINT, 12'd103, 12'd103);
      queue_marker(KIND_GRAPH_END);
      settle();

      // symbol mode, zero tolerance
      set_config(12'd100, 12'd100, 1'b1, 16'hFFFF, 4'd0);
      queue_marker(KIND_STROKE_END);
      queue_item(KIND_POINT, 12'd101, 12'd100);
      queue_marker(KIND_BRANCH_END);
      queue_item(KIND_POINT, 12'd100, 12'd100);
      queue_marker(KIND_GRAPH_END);
      settle();

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 60; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 60; end
            default: begin req_idle_pct = 25; rsp_stall_pct = 25; end
         endcase
         if (p == 0)
            set_config(12'd0, 12'd4095, 1'b0, 16'd0, 4'd15);
         else if (p == 1)
            set_config(12'd4095, 12'd0, 1'b1, 16'hFFFF, 4'd0);
         else
            set_config(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                       1'((p & 1) ^ ((p >> 2) & 1)),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 8))
                                                   : 16'($urandom_range(1, 65535)),
                       4'($urandom_range(0, 15)));
         queued_in_phase = 0;
         graphs = 0;
         if (p == 1) begin
            // saturate the branch count, then hit
            repeat (MAX_BRANCHES_DEFAULT) queue_marker(KIND_BRANCH_END);
            queue_item(KIND_POINT, cfg_qx, cfg_qy);
            queue_item(KIND_POINT, cfg_qx, cfg_qy);
            queue_marker(KIND_GRAPH_END);
            queued_in_phase = 0;
         end
         while (graphs < 6 || queued_in_phase < 35) begin
            queue_graph(int'(cfg_tol) + 6, p == 2 && graphs == 1);
            graphs++;
         end
         settle();
      end

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
